/* rtl/cau_pkg.sv */
package cau_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_SAT    = 2'd2
  } status_e;

endpackage

/* rtl/complex_arith_unit.sv */
// a transaction passes stage 1, stage 2, the divider load register, the divider stages and the output register
// throughput: one transaction per cycle while the output is not stalled; the divider retires one quotient bit per stage
// a stalled output freezes the whole pipeline, the input is ready whenever it moves
// reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset
module complex_arith_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // cmd
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // res_real, res_imag
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  // status
  output logic [1:0]                           m_axis_tuser
);
  import cau_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int PW  = 2 * DW;
  localparam int MW  = 2 * DW + 1;
  localparam int NW  = 2 * DW + FRAC_BITS;
  localparam int QW  = DW + 1;
  localparam int ODW = ((2 * DW + 7) / 8) * 8;

  typedef struct packed {
    logic          fin;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic [MW-1:0] mre;
    logic [MW-1:0] mim;
    logic [NW-1:0] nre;
    logic [NW-1:0] nim;
    logic [PW-1:0] rre;
    logic [PW-1:0] rim;
    logic [PW-1:0] den;
    logic [QW-1:0] qre;
    logic [QW-1:0] qim;
    logic          ovre;
    logic          ovim;
  } dstage_t;

  function automatic logic [PW:0] div_bit(input logic [PW-1:0] r, input logic nb,
                                          input logic [PW-1:0] d);
    logic [PW:0] t;
    logic [PW:0] diff;
    t    = {r, nb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[PW-1:0]};
    end else begin
      return {1'b0, t[PW-1:0]};
    end
  endfunction

  function automatic logic [DW:0] sat_val(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] half;
    logic [DW-1:0] v;
    logic          s;
    half = MW'(1) << (DW - 1);
    s    = 1'b0;
    if (neg) begin
      if (mag > half) begin
        s = 1'b1;
        v = {1'b1, {(DW-1){1'b0}}};
      end else begin
        v = -mag[DW-1:0];
      end
    end else begin
      if (mag > half - MW'(1)) begin
        s = 1'b1;
        v = {1'b0, {(DW-1){1'b1}}};
      end else begin
        v = mag[DW-1:0];
      end
    end
    return {s, v};
  endfunction

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: operand capture
  logic                 s1_vld_q;
  cmd_e                 s1_cmd_q;
  logic signed [DW-1:0] ar_q, ai_q, br_q, bi_q;

  // stage 2: products and sums
  logic                 s2_vld_q;
  cmd_e                 s2_cmd_q;
  logic signed [PW-1:0] p_arbr_q, p_aibi_q, p_arbi_q, p_aibr_q, p_brbr_q, p_bibi_q;
  logic signed [DW:0]   sum_re_q, sum_im_q;

  // divider stages
  logic                 dv_q [NW+1];
  dstage_t              st_q [NW+1];
  dstage_t              st_d [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      dv_q[0]  <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
      s2_vld_q <= s1_vld_q;
      dv_q[0]  <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q <= cmd_e'(s_axis_tuser);
      ar_q     <= s_axis_tdata[DW-1:0];
      ai_q     <= s_axis_tdata[2*DW-1:DW];
      br_q     <= s_axis_tdata[3*DW-1:2*DW];
      bi_q     <= s_axis_tdata[4*DW-1:3*DW];
      s2_cmd_q <= s1_cmd_q;
      p_arbr_q <= ar_q * br_q;
      p_aibi_q <= ai_q * bi_q;
      p_arbi_q <= ar_q * bi_q;
      p_aibr_q <= ai_q * br_q;
      p_brbr_q <= br_q * br_q;
      p_bibi_q <= bi_q * bi_q;
      if (s1_cmd_q == CMD_SUB) begin
        sum_re_q <= (DW+1)'(ar_q) - (DW+1)'(br_q);
        sum_im_q <= (DW+1)'(ai_q) - (DW+1)'(bi_q);
      end else begin
        sum_re_q <= (DW+1)'(ar_q) + (DW+1)'(br_q);
        sum_im_q <= (DW+1)'(ai_q) + (DW+1)'(bi_q);
      end
      st_q[0] <= st_d[0];
    end
  end

  // stage 3: combine into sign and magnitude, load the divider
  logic signed [MW-1:0] vre, vim;
  logic        [MW-1:0] are, aim;
  logic        [PW-1:0] den;

  always_comb begin
    unique case (s2_cmd_q)
      CMD_ADD, CMD_SUB: begin
        vre = MW'(sum_re_q);
        vim = MW'(sum_im_q);
      end
      CMD_MUL: begin
        vre = MW'(p_arbr_q) - MW'(p_aibi_q);
        vim = MW'(p_arbi_q) + MW'(p_aibr_q);
      end
      default: begin
        vre = MW'(p_arbr_q) + MW'(p_aibi_q);
        vim = MW'(p_aibr_q) - MW'(p_arbi_q);
      end
    endcase
    are = vre[MW-1] ? MW'(-vre) : MW'(vre);
    aim = vim[MW-1] ? MW'(-vim) : MW'(vim);
    den = PW'($unsigned(p_brbr_q)) + PW'($unsigned(p_bibi_q));

    st_d[0]        = '0;
    st_d[0].fin    = (s2_cmd_q != CMD_DIV);
    st_d[0].dz     = (s2_cmd_q == CMD_DIV) && (den == '0);
    st_d[0].neg_re = vre[MW-1];
    st_d[0].neg_im = vim[MW-1];
    st_d[0].den    = den;
    if (s2_cmd_q == CMD_MUL) begin
      st_d[0].mre = are >> FRAC_BITS;
      st_d[0].mim = aim >> FRAC_BITS;
    end else begin
      st_d[0].mre = are;
      st_d[0].mim = aim;
    end
    st_d[0].nre = NW'(are[PW-1:0]) << FRAC_BITS;
    st_d[0].nim = NW'(aim[PW-1:0]) << FRAC_BITS;
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [PW:0] bre, bim;

    assign bre = div_bit(st_q[k].rre, st_q[k].nre[NW-1], st_q[k].den);
    assign bim = div_bit(st_q[k].rim, st_q[k].nim[NW-1], st_q[k].den);

    always_comb begin
      st_d[k+1]      = st_q[k];
      st_d[k+1].nre  = st_q[k].nre << 1;
      st_d[k+1].nim  = st_q[k].nim << 1;
      st_d[k+1].rre  = bre[PW-1:0];
      st_d[k+1].rim  = bim[PW-1:0];
      st_d[k+1].qre  = {st_q[k].qre[QW-2:0], bre[PW]};
      st_d[k+1].qim  = {st_q[k].qim[QW-2:0], bim[PW]};
      st_d[k+1].ovre = st_q[k].ovre | st_q[k].qre[QW-1];
      st_d[k+1].ovim = st_q[k].ovim | st_q[k].qim[QW-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k+1] <= st_d[k+1];
      end
    end
  end

  // output stage: select, saturate, flag divide by zero
  dstage_t       fs;
  logic [MW-1:0] fre, fim;
  logic [DW:0]   sre, sim;
  logic [DW-1:0] res_re_d, res_im_d, res_re_q, res_im_q;
  status_e       status_d, status_q;

  always_comb begin
    fs = st_q[NW];
    if (fs.fin) begin
      fre = fs.mre;
      fim = fs.mim;
    end else begin
      fre = fs.ovre ? (MW'(1) << DW) : MW'(fs.qre);
      fim = fs.ovim ? (MW'(1) << DW) : MW'(fs.qim);
    end
    sre = sat_val(fs.neg_re, fre);
    sim = sat_val(fs.neg_im, fim);
    if (fs.dz) begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = ST_DIVZERO;
    end else begin
      res_re_d = sre[DW-1:0];
      res_im_d = sim[DW-1:0];
      status_d = (sre[DW] || sim[DW]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = ODW'({res_im_q, res_re_q});
  assign m_axis_tuser  = status_q;

endmodule

/* rtl/cau_checker.sv */
module cau_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;

  logic [DW-1:0] re, im;
  logic          re_ext, im_ext;

  assign re     = m_axis_tdata[DW-1:0];
  assign im     = m_axis_tdata[2*DW-1:DW];
  assign re_ext = (re == {1'b0, {(DW-1){1'b1}}}) || (re == {1'b1, {(DW-1){1'b0}}});
  assign im_ext = (im == {1'b0, {(DW-1){1'b1}}}) || (im == {1'b1, {(DW-1){1'b0}}});

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_divzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_DIVZERO |-> re == '0 && im == '0)
    else $error("divide by zero result not zero");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_SAT |-> re_ext || im_ext)
    else $error("saturated result not at a range limit");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_DIVZERO
      || m_axis_tuser == ST_SAT)
    else $error("unused status code");

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
